// ===== rtl/core/sotlen_pkg.sv =====
`timescale 1ns / 1ps

package sotlen_pkg;

    localparam int MAX_PAYLOAD = 127;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_START    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROTOCOL = 2'd2;

    localparam logic [7:0] START_RESET    = 8'h01;
    localparam logic [7:0] END_RESET      = 8'h04;
    localparam logic [7:0] PROTOCOL_RESET = 8'h00;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_END  = 2'd1;
    localparam logic [1:0] ST_BAD_PROT = 2'd2;
    localparam logic [1:0] ST_OVERSIZE = 2'd3;

    typedef struct packed {
        logic [7:0] start_byte;
        logic [7:0] end_byte;
        logic [7:0] protocol_value;
    } t_cfg;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic [6:0] byte_index;
        logic [1:0] status;
        logic [7:0] message_id;
        logic [7:0] frame_length;
    } t_result;

endpackage

// ===== rtl/core/sotlen_cfg_regs.sv =====
`timescale 1ns / 1ps

module sotlen_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [sotlen_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                       i_cfg_data,
    output sotlen_pkg::t_cfg                 o_cfg
);

    sotlen_pkg::t_cfg r_cfg;
    sotlen_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                sotlen_pkg::CFG_START:    n_cfg.start_byte     = i_cfg_data;
                sotlen_pkg::CFG_END:      n_cfg.end_byte       = i_cfg_data;
                sotlen_pkg::CFG_PROTOCOL: n_cfg.protocol_value = i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_byte     <= sotlen_pkg::START_RESET;
            r_cfg.end_byte       <= sotlen_pkg::END_RESET;
            r_cfg.protocol_value <= sotlen_pkg::PROTOCOL_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/sotlen_parser.sv =====
`timescale 1ns / 1ps

module sotlen_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_rx_byte,
    input  sotlen_pkg::t_cfg    i_cfg,
    output logic                o_res_valid,
    output sotlen_pkg::t_result o_res
);

    localparam logic [1:0] PH_HUNT = 2'd0;
    localparam logic [1:0] PH_LEN  = 2'd1;
    localparam logic [1:0] PH_DATA = 2'd2;
    localparam logic [1:0] PH_END  = 2'd3;

    logic [1:0] r_phase,          n_phase;
    logic [7:0] r_remaining,      n_remaining;
    logic [6:0] r_position,       n_position;
    logic [7:0] r_length_seen,    n_length_seen;
    logic       r_protocol_match, n_protocol_match;
    logic [7:0] r_captured_id,    n_captured_id;

    always_comb begin
        n_phase          = r_phase;
        n_remaining      = r_remaining;
        n_position       = r_position;
        n_length_seen    = r_length_seen;
        n_protocol_match = r_protocol_match;
        n_captured_id    = r_captured_id;
        o_res_valid      = 1'b0;
        o_res            = '0;

        unique case (r_phase)
            PH_HUNT: begin
                if (i_rx_byte == i_cfg.start_byte) begin
                    n_phase = PH_LEN;
                end
            end
            PH_LEN: begin
                if (i_rx_byte == 8'd0) begin
                    n_phase = PH_HUNT;
                end else if (i_rx_byte > 8'(sotlen_pkg::MAX_PAYLOAD)) begin
                    n_phase            = PH_HUNT;
                    o_res_valid        = 1'b1;
                    o_res.kind         = sotlen_pkg::KIND_STATUS;
                    o_res.status       = sotlen_pkg::ST_OVERSIZE;
                    o_res.frame_length = i_rx_byte;
                end else begin
                    n_length_seen    = i_rx_byte;
                    n_remaining      = i_rx_byte;
                    n_position       = '0;
                    n_protocol_match = 1'b0;
                    n_captured_id    = '0;
                    n_phase          = PH_DATA;
                end
            end
            PH_DATA: begin
                if (r_position == 7'd0) begin
                    n_protocol_match = (i_rx_byte == i_cfg.protocol_value);
                end else if (r_position == 7'd1) begin
                    n_captured_id = i_rx_byte;
                end
                o_res_valid      = 1'b1;
                o_res.data_byte  = i_rx_byte;
                o_res.byte_index = r_position;
                n_position       = r_position + 7'd1;
                n_remaining      = r_remaining - 8'd1;
                if (r_remaining == 8'd1) begin
                    n_phase = PH_END;
                end
            end
            PH_END: begin
                n_phase            = PH_HUNT;
                o_res_valid        = 1'b1;
                o_res.kind         = sotlen_pkg::KIND_STATUS;
                o_res.frame_length = r_length_seen;
                if (i_rx_byte != i_cfg.end_byte) begin
                    o_res.status = sotlen_pkg::ST_BAD_END;
                end else if (!r_protocol_match) begin
                    o_res.status = sotlen_pkg::ST_BAD_PROT;
                end else begin
                    o_res.status     = sotlen_pkg::ST_OK;
                    o_res.message_id = (r_length_seen >= 8'd2) ? r_captured_id : 8'd0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= PH_HUNT;
            r_remaining      <= '0;
            r_position       <= '0;
            r_length_seen    <= '0;
            r_protocol_match <= 1'b0;
            r_captured_id    <= '0;
        end else if (i_accept) begin
            r_phase          <= n_phase;
            r_remaining      <= n_remaining;
            r_position       <= n_position;
            r_length_seen    <= n_length_seen;
            r_protocol_match <= n_protocol_match;
            r_captured_id    <= n_captured_id;
        end
    end

endmodule

// ===== rtl/core/sotlen_out_reg.sv =====
`timescale 1ns / 1ps

module sotlen_out_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  logic                i_res_valid,
    input  sotlen_pkg::t_result i_res,
    input  logic                i_ready,
    output logic                o_valid,
    output logic                o_free,
    output sotlen_pkg::t_result o_res
);

    logic                r_valid;
    logic                n_valid;
    sotlen_pkg::t_result r_res;

    // load only happens when the slot is empty or draining this cycle
    assign o_free  = !r_valid || i_ready;
    assign n_valid = i_load ? i_res_valid : (r_valid && !i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// ===== rtl/core/sot_length_eot_frame_receiver.sv =====
`timescale 1ns / 1ps

// Start/length/end framed byte receiver.
// Input channel: i_valid / o_ready carry one received byte (i_rx_byte) per word.
// Output channel: o_valid / i_ready carry one result word: either a payload
// byte with its index (o_kind = 0) or an end-of-frame status (o_kind = 1)
// with message id and frame length.
// A result appears on the output in the cycle after the byte that
// causes it is accepted. Throughput: one byte per cycle, back to back, while the output register is free.
// Bytes that produce no result (hunt, length, zero length) are consumed
// without touching the output.
// The output is a single register; a byte is accepted whenever that register
// is empty or being taken in the same cycle. If the receiver stalls, o_ready
// drops until the pending result is taken, and no result is lost.
// Configuration (start byte, end byte, protocol value) is written through
// i_cfg_we / i_cfg_index / i_cfg_data; the user must do so only while the block is idle (unchecked).
// Reset (i_rst_n low, synchronous) returns to the start-byte hunt, empties
// the output register and loads the default delimiters 0x01 and 0x04.

module sot_length_eot_frame_receiver (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [sotlen_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                       i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [7:0]                       i_rx_byte,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic                             o_kind,
    output logic [7:0]                       o_data_byte,
    output logic [6:0]                       o_byte_index,
    output logic [1:0]                       o_status,
    output logic [7:0]                       o_message_id,
    output logic [7:0]                       o_frame_length
);

    sotlen_pkg::t_cfg    cfg;
    sotlen_pkg::t_result res;
    sotlen_pkg::t_result out_res;
    logic                res_valid;
    logic                out_free;
    logic                accept;

    assign accept  = i_valid && out_free;
    assign o_ready = out_free;

    sotlen_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    sotlen_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_rx_byte   (i_rx_byte),
        .i_cfg       (cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    sotlen_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept),
        .i_res_valid (res_valid),
        .i_res       (res),
        .i_ready     (i_ready),
        .o_valid     (o_valid),
        .o_free      (out_free),
        .o_res       (out_res)
    );

    assign o_kind         = out_res.kind;
    assign o_data_byte    = out_res.data_byte;
    assign o_byte_index   = out_res.byte_index;
    assign o_status       = out_res.status;
    assign o_message_id   = out_res.message_id;
    assign o_frame_length = out_res.frame_length;

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_empty_accepts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled while output register empty");

    a_payload_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == sotlen_pkg::KIND_PAYLOAD)
            |-> (o_status == 2'd0 && o_message_id == 8'd0 && o_frame_length == 8'd0))
        else $error("payload word carries status fields");

    a_status_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == sotlen_pkg::KIND_STATUS)
            |-> (o_data_byte == 8'd0 && o_byte_index == 7'd0
                 && (o_status == sotlen_pkg::ST_OK || o_message_id == 8'd0)))
        else $error("status word carries payload fields");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int          CYCLE_LIMIT = 400000;
    localparam int          PHASE_WORDS = 160;
    localparam int          N_PHASES    = 5;
    localparam int          MAX_GAP     = 40;
    localparam logic [1:0]  CFG_SPARE   = 2'd3;

    typedef enum logic [1:0] {PH_HUNT, PH_LENGTH, PH_PAYLOAD, PH_TRAILER} t_frame_phase;
    typedef enum logic [1:0] {ROW_PREDICT, ROW_SILENT, ROW_STATUS} t_row_check;

    typedef struct packed {
        logic [7:0] rx;
        t_row_check how;
        logic [1:0] st;
        logic [7:0] id;
        logic [7:0] len;
    } t_dir_row;

    localparam t_dir_row DIR_ROWS [25] = '{
        '{8'hFF, ROW_SILENT,  sotlen_pkg::ST_OK,       8'h00, 8'h00},
        '{8'h01, ROW_SILENT,  sotlen_pkg::ST_OK,       8'h00, 8'h00},
        '{8'h80, ROW_STATUS,  sotlen_pkg::ST_OVERSIZE, 8'h00, 8'h80},
        '{8'h01, ROW_SILENT,  sotlen_pkg::ST_OK,       8'h00, 8'h00},
        '{8'hFF, ROW_STATUS,  sotlen_pkg::ST_OVERSIZE, 8'h00, 8'hFF},
        '{8'h01, ROW_SILENT,  sotlen_pkg::ST_OK,       8'h00, 8'h00},
        '{8'h00, ROW_SILENT,  sotlen_pkg::ST_OK,       8'h00, 8'h00},
        '{8'h01, ROW_SILENT,  sotlen_pkg::ST_OK,       8'h00, 8'h00},
        '{8'h01, ROW_SILENT,  sotlen_pkg::ST_OK,       8'h00, 8'h00},
        '{8'h00, ROW_PREDICT, sotlen_pkg::ST_OK,       8'h00, 8'h00},
        '{8'h04, ROW_STATUS,  sotlen_pkg::ST_OK,       8'h00, 8'h01},
        '{8'h01, ROW_SILENT,  sotlen_pkg::ST_OK,       8'h00, 8'h00},
        '{8'h02, ROW_SILENT,  sotlen_pkg::ST_OK,       8'h00, 8'h00},
        '{8'h07, ROW_PREDICT, sotlen_pkg::ST_OK,       8'h00, 8'h00},
        '{8'hFF, ROW_PREDICT, sotlen_pkg::ST_OK,       8'h00, 8'h00},
        '{8'h04, ROW_STATUS,  sotlen_pkg::ST_BAD_PROT, 8'h00, 8'h02},
        '{8'h01, ROW_SILENT,  sotlen_pkg::ST_OK,       8'h00, 8'h00},
        '{8'h01, ROW_SILENT,  sotlen_pkg::ST_OK,       8'h00, 8'h00},
        '{8'h07, ROW_PREDICT, sotlen_pkg::ST_OK,       8'h00, 8'h00},
        '{8'h05, ROW_STATUS,  sotlen_pkg::ST_BAD_END,  8'h00, 8'h01},
        '{8'h01, ROW_SILENT,  sotlen_pkg::ST_OK,       8'h00, 8'h00},
        '{8'h02, ROW_SILENT,  sotlen_pkg::ST_OK,       8'h00, 8'h00},
        '{8'h00, ROW_PREDICT, sotlen_pkg::ST_OK,       8'h00, 8'h00},
        '{8'h5A, ROW_PREDICT, sotlen_pkg::ST_OK,       8'h00, 8'h00},
        '{8'h04, ROW_STATUS,  sotlen_pkg::ST_OK,       8'h5A, 8'h02}
    };

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [sotlen_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [7:0]                      i_cfg_data;
    logic                            i_valid;
    logic                            o_ready;
    logic [7:0]                      i_rx_byte;
    logic                            o_valid;
    logic                            i_ready;
    logic                            o_kind;
    logic [7:0]                      o_data_byte;
    logic [6:0]                      o_byte_index;
    logic [1:0]                      o_status;
    logic [7:0]                      o_message_id;
    logic [7:0]                      o_frame_length;

    sot_length_eot_frame_receiver i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_rx_byte      (i_rx_byte),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_kind         (o_kind),
        .o_data_byte    (o_data_byte),
        .o_byte_index   (o_byte_index),
        .o_status       (o_status),
        .o_message_id   (o_message_id),
        .o_frame_length (o_frame_length)
    );

    always #5 i_clk = ~i_clk;

    logic [7:0]   reg_start    = sotlen_pkg::START_RESET;
    logic [7:0]   reg_end      = sotlen_pkg::END_RESET;
    logic [7:0]   reg_protocol = sotlen_pkg::PROTOCOL_RESET;

    t_frame_phase fr_phase     = PH_HUNT;
    logic [7:0]   fr_remaining = '0;
    logic [6:0]   fr_position  = '0;
    logic [7:0]   fr_length    = '0;
    logic         fr_proto_ok  = 1'b0;
    logic [7:0]   fr_msg_id    = '0;

    sotlen_pkg::t_result results_due[$];

    int           tx_idle_pct  = 0;
    int           rx_stall_pct = 0;
    int unsigned  cycle_count  = 0;
    int unsigned  n_fail       = 0;
    int unsigned  n_words_in   = 0;
    int unsigned  n_checked    = 0;
    int unsigned  n_status [4] = '{0, 0, 0, 0};

    function automatic bit deframe_byte(input logic [7:0] b,
                                        output sotlen_pkg::t_result r);
        r = '0;
        deframe_byte = 1'b0;
        case (fr_phase)
            PH_HUNT: begin
                if (b == reg_start) fr_phase = PH_LENGTH;
            end
            PH_LENGTH: begin
                if (b == 8'd0) begin
                    fr_phase = PH_HUNT;
                end else if (b > 8'(sotlen_pkg::MAX_PAYLOAD)) begin
                    fr_phase       = PH_HUNT;
                    r.kind         = sotlen_pkg::KIND_STATUS;
                    r.status       = sotlen_pkg::ST_OVERSIZE;
                    r.frame_length = b;
                    deframe_byte   = 1'b1;
                end else begin
                    fr_length    = b;
                    fr_remaining = b;
                    fr_position  = '0;
                    fr_proto_ok  = 1'b0;
                    fr_msg_id    = '0;
                    fr_phase     = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                if (fr_position == 7'd0) fr_proto_ok = (b == reg_protocol);
                else if (fr_position == 7'd1) fr_msg_id = b;
                r.kind       = sotlen_pkg::KIND_PAYLOAD;
                r.data_byte  = b;
                r.byte_index = fr_position;
                deframe_byte = 1'b1;
                fr_position  = fr_position + 7'd1;
                fr_remaining = fr_remaining - 8'd1;
                if (fr_remaining == 8'd0) fr_phase = PH_TRAILER;
            end
            default: begin
                fr_phase       = PH_HUNT;
                r.kind         = sotlen_pkg::KIND_STATUS;
                r.frame_length = fr_length;
                deframe_byte   = 1'b1;
                if (b != reg_end) begin
                    r.status = sotlen_pkg::ST_BAD_END;
                end else if (!fr_proto_ok) begin
                    r.status = sotlen_pkg::ST_BAD_PROT;
                end else begin
                    r.status     = sotlen_pkg::ST_OK;
                    r.message_id = (fr_length >= 8'd2) ? fr_msg_id : 8'd0;
                end
            end
        endcase
    endfunction

    task automatic send_byte(input t_dir_row row);
        int unsigned         gap;
        sotlen_pkg::t_result r;
        bit                  has;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= row.rx;
        do @(posedge i_clk); while (!o_ready);
        n_words_in++;
        has = deframe_byte(row.rx, r);
        case (row.how)
            ROW_PREDICT: if (has) results_due.push_back(r);
            ROW_STATUS: begin
                r = '0;
                r.kind         = sotlen_pkg::KIND_STATUS;
                r.status       = row.st;
                r.message_id   = row.id;
                r.frame_length = row.len;
                results_due.push_back(r);
            end
            default: ;
        endcase
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (results_due.size() != 0);
    endtask

    task automatic set_config(input logic [7:0] s, input logic [7:0] e,
                              input logic [7:0] p);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= sotlen_pkg::CFG_START;
        i_cfg_data  <= s;
        @(posedge i_clk);
        i_cfg_index <= sotlen_pkg::CFG_END;
        i_cfg_data  <= e;
        @(posedge i_clk);
        i_cfg_index <= sotlen_pkg::CFG_PROTOCOL;
        i_cfg_data  <= p;
        @(posedge i_clk);
        // unused index, must not disturb anything
        i_cfg_index <= CFG_SPARE;
        i_cfg_data  <= ~s;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        reg_start    = s;
        reg_end      = e;
        reg_protocol = p;
    endtask

    task automatic send_frame(output int unsigned n_sent);
        t_dir_row    w;
        int unsigned len;
        int unsigned pick;
        int unsigned noise;
        w = '0;
        n_sent = 0;
        noise = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
        repeat (noise) begin
            do w.rx = 8'($urandom); while (w.rx == reg_start);
            send_byte(w);
        end
        pick = $urandom_range(99);
        if (pick < 4)       len = 0;
        else if (pick < 10) len = $urandom_range(sotlen_pkg::MAX_PAYLOAD + 1, 255);
        else if (pick < 12) len = sotlen_pkg::MAX_PAYLOAD;
        else if (pick < 18) len = $urandom_range(9, sotlen_pkg::MAX_PAYLOAD - 1);
        else                len = $urandom_range(1, 8);
        w.rx = reg_start;
        send_byte(w);
        w.rx = len[7:0];
        send_byte(w);
        n_sent = 2;
        if (len == 0 || len > sotlen_pkg::MAX_PAYLOAD) return;
        for (int i = 0; i < len; i++) begin
            w.rx = (i == 0 && $urandom_range(99) < 75) ? reg_protocol : 8'($urandom);
            send_byte(w);
        end
        w.rx = ($urandom_range(99) < 80) ? reg_end : 8'($urandom);
        send_byte(w);
        n_sent += len + 1;
    endtask

    task automatic cmp_field(input string name, input int unsigned want,
                             input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            n_fail++;
        end
    endtask

    task automatic check_result_word();
        sotlen_pkg::t_result want;
        if (results_due.size() == 0) begin
            $error("unexpected word: kind %0d data %0h index %0d status %0d",
                   o_kind, o_data_byte, o_byte_index, o_status);
            n_fail++;
        end else begin
            want = results_due.pop_front();
            n_checked++;
            if (want.kind == sotlen_pkg::KIND_STATUS) n_status[want.status]++;
            cmp_field("kind",         32'(want.kind),         32'(o_kind));
            cmp_field("data_byte",    32'(want.data_byte),    32'(o_data_byte));
            cmp_field("byte_index",   32'(want.byte_index),   32'(o_byte_index));
            cmp_field("status",       32'(want.status),       32'(o_status));
            cmp_field("message_id",   32'(want.message_id),   32'(o_message_id));
            cmp_field("frame_length", 32'(want.frame_length), 32'(o_frame_length));
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) check_result_word();
        i_ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        int unsigned n_phase_words;
        int unsigned n_frame_words;
        int unsigned n_frames;
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= sotlen_pkg::CFG_START;
        i_cfg_data  <= '0;
        i_valid     <= 1'b0;
        i_rx_byte   <= '0;
        i_ready     <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIR_ROWS[k]) send_byte(DIR_ROWS[k]);

        for (int p = 0; p < N_PHASES; p++) begin
            drain_results();
            repeat (4) @(posedge i_clk);
            case (p)
                0: begin
                    set_config(8'h00, 8'hFF, 8'hFF);
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
                1: begin
                    set_config(8'hFF, 8'h00, 8'h00);
                    tx_idle_pct  = 77;
                    rx_stall_pct = 0;
                end
                2: begin
                    set_config(8'($urandom), 8'($urandom), 8'($urandom));
                    tx_idle_pct  = 0;
                    rx_stall_pct = 77;
                end
                3: begin
                    set_config(8'($urandom), 8'($urandom), 8'($urandom));
                    tx_idle_pct  = 23;
                    rx_stall_pct = 23;
                end
                default: begin
                    set_config(8'($urandom), 8'($urandom), 8'($urandom));
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
            endcase
            n_phase_words = 0;
            n_frames      = 0;
            while (n_phase_words < PHASE_WORDS) begin
                send_frame(n_frame_words);
                n_phase_words += n_frame_words;
                // hold off the sender until the output side has caught up
                if (p == 1 && n_frames % 4 == 0) drain_results();
                n_frames++;
            end
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        if (results_due.size() != 0)
            $error("%0d result words never arrived", results_due.size());

        $display("Sent %0d bytes over %0d register settings; checked %0d result words.",
                 n_words_in, N_PHASES + 1, n_checked);
        $display("Frame status words: %0d accepted, %0d bad end, %0d bad protocol, %0d %s",
                 n_status[sotlen_pkg::ST_OK], n_status[sotlen_pkg::ST_BAD_END],
                 n_status[sotlen_pkg::ST_BAD_PROT], n_status[sotlen_pkg::ST_OVERSIZE],
                 "oversize.");
        if (n_fail == 0 && results_due.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== sot_length_eot_frame_receiver.f =====
rtl/core/sotlen_pkg.sv
rtl/core/sotlen_cfg_regs.sv
rtl/core/sotlen_parser.sv
rtl/core/sotlen_out_reg.sv
rtl/core/sot_length_eot_frame_receiver.sv
verif/tb_top.sv
